// File: rtl/core/ole_pkg.sv
// Shared types and constants of the ordered list engine.
package ole_pkg;

   localparam int unsigned ACTION_W = 3;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_INSERT     = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_POP_BACK   = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_COMMIT,
      S_REPORT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
      logic report;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

// File: rtl/core/ole_ctrl.sv
// Sequencing state machine of the ordered list engine.
module ole_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ole_pkg::dp_stat_type dp_stat,
   output ole_pkg::dp_cmd_type  dp_cmd
);
   import ole_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_COMPARE;
         end
         S_COMPARE: state_in = S_COMMIT;
         S_COMMIT:  state_in = S_REPORT;
         S_REPORT: begin
            if (dp_stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = (state_ff != S_IDLE);
      dp_cmd.load    = (state_ff == S_IDLE) && req_valid;
      dp_cmd.compare = (state_ff == S_COMPARE);
      dp_cmd.commit  = (state_ff == S_COMMIT);
      dp_cmd.report  = (state_ff == S_REPORT) && dp_stat.out_free;
   end

endmodule

// File: rtl/core/ole_dpath.sv
// Slot chain, compare row and result register of the ordered list engine.
module ole_dpath #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ole_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [ole_pkg::VALUE_W-1:0]  req_value,
   input  ole_pkg::dp_cmd_type                 dp_cmd,
   output ole_pkg::dp_stat_type                dp_stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ole_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ole_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [ole_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic signed [ole_pkg::VALUE_W-1:0]  rsp_first_value,
   output logic signed [ole_pkg::VALUE_W-1:0]  rsp_last_value
);
   import ole_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   // request registers
   logic [ACTION_W-1:0]       act_ff;
   logic signed [VALUE_W-1:0] val_ff;

   // slot chain, front at index 0; valid is a thermometer code
   logic signed [VALUE_W-1:0] slot_ff [CAPACITY];
   logic signed [VALUE_W-1:0] slot_in [CAPACITY];
   logic [CAPACITY-1:0]       valid_ff;
   logic [CAPACITY-1:0]       valid_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      state_we;

   // per-cell "stored entry less than value"
   logic [CAPACITY-1:0]       lt_ff;
   logic [CAPACITY-1:0]       lt_in;
   logic [CAPACITY-1:0]       keep;
   logic                      keep_prev;

   logic [CAPACITY-1:0]       is_last;
   logic signed [VALUE_W-1:0] last_sel;
   logic                      full;
   logic                      empty;

   logic [STATUS_W-1:0]       status_ff;
   logic [STATUS_W-1:0]       status_in;
   logic signed [VALUE_W-1:0] removed_ff;
   logic signed [VALUE_W-1:0] removed_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_removed_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic signed [VALUE_W-1:0] rsp_first_ff;
   logic signed [VALUE_W-1:0] rsp_last_ff;
   logic [CNT_W+COUNT_W-1:0]  count_wide;

   assign full  = valid_ff[CAPACITY-1];
   assign empty = !valid_ff[0];

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_in[i] = valid_ff[i] && (slot_ff[i] < val_ff);
      end
   end

   // back entry picked by the valid edge
   always_comb begin
      last_sel = '0;
      for (int i = 0; i < CAPACITY - 1; i++) begin
         is_last[i] = valid_ff[i] && !valid_ff[i+1];
      end
      is_last[CAPACITY-1] = valid_ff[CAPACITY-1];
      for (int i = 0; i < CAPACITY; i++) begin
         last_sel = last_sel | (slot_ff[i] & {VALUE_W{is_last[i]}});
      end
   end

   // keep[i]: cell i holds its entry on a push; the new value lands on the first cleared cell
   always_comb begin
      keep_prev = 1'b1;
      for (int i = 0; i < CAPACITY; i++) begin
         unique case (act_ff)
            ACT_PUSH_BACK: keep[i] = valid_ff[i];
            ACT_INSERT:    keep[i] = keep_prev && lt_ff[i];
            default:       keep[i] = 1'b0;
         endcase
         keep_prev = keep[i];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_in[i] = slot_ff[i];
      end
      valid_in   = valid_ff;
      count_in   = count_ff;
      status_in  = ST_DONE;
      removed_in = '0;
      state_we   = 1'b0;
      unique case (act_ff)
         ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               state_we   = 1'b1;
               slot_in[0] = keep[0] ? slot_ff[0] : val_ff;
               for (int i = 1; i < CAPACITY; i++) begin
                  slot_in[i] = keep[i]   ? slot_ff[i] :
                               keep[i-1] ? val_ff     : slot_ff[i-1];
               end
               valid_in = {valid_ff[CAPACITY-2:0], 1'b1};
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               state_we   = 1'b1;
               removed_in = slot_ff[0];
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  slot_in[i] = slot_ff[i+1];
               end
               valid_in = {1'b0, valid_ff[CAPACITY-1:1]};
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               state_we   = 1'b1;
               removed_in = last_sel;
               valid_in   = {1'b0, valid_ff[CAPACITY-1:1]};
               count_in   = count_ff - CNT_W'(1);
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   assign dp_stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.report) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.commit && state_we) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         act_ff <= req_action;
         val_ff <= req_value;
      end
      if (dp_cmd.compare) begin
         lt_ff <= lt_in;
      end
      if (dp_cmd.commit) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         if (state_we) begin
            for (int i = 0; i < CAPACITY; i++) begin
               slot_ff[i] <= slot_in[i];
            end
         end
      end
      if (dp_cmd.report) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_count_ff   <= count_wide[COUNT_W-1:0];
         rsp_first_ff   <= valid_ff[0] ? slot_ff[0] : '0;
         rsp_last_ff    <= last_sel;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_first_value   = rsp_first_ff;
   assign rsp_last_value    = rsp_last_ff;

endmodule

// File: rtl/core/ordered_list_engine_core.sv
// Top level of the ordered list engine: bounded sorted list / deque of signed words.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  action, value
//   rsp_      out        rsp_valid / rsp_stall  status, removed_value, entry_count,
//                                               first_value, last_value
//
// One request is in flight at a time: accept, compare row, commit, report. rsp_valid rises
// when the report step loads the output register, and with rsp_stall low the next request
// is taken once the controller's four-state sequence is back in idle, with the compare
// row registered ahead of commit.
// The result sits in an output register, so the next request is accepted while the
// previous result still waits on rsp_stall; only a second finished result stalls the
// report step. Synchronous active-high reset empties the list at once (no clearing pass).
module ordered_list_engine_core #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ole_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [ole_pkg::VALUE_W-1:0]  req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ole_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [ole_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic [ole_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic signed [ole_pkg::VALUE_W-1:0]  rsp_first_value,
   output logic signed [ole_pkg::VALUE_W-1:0]  rsp_last_value
);
   import ole_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Sequencer: steps each transaction through compare, commit and report.
   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // Datapath: slot chain with per-cell compare; pushes shift the tail back one cell,
   // pop front shifts everything forward, pop back only drops the valid edge.
   ole_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_value         (req_value),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_first_value   (rsp_first_value),
      .rsp_last_value    (rsp_last_value)
   );

endmodule

// File: tb/sv/ordered_list_checker.sv
// Checker for the ordered list engine: tracks the list, predicts each response and compares.
`timescale 1ns / 100ps

module ordered_list_checker #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [ole_pkg::ACTION_W-1:0]        req_action,
   input  logic signed [ole_pkg::VALUE_W-1:0]  req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [ole_pkg::STATUS_W-1:0]        rsp_status,
   input  logic signed [ole_pkg::VALUE_W-1:0]  rsp_removed_value,
   input  logic [ole_pkg::COUNT_W-1:0]         rsp_entry_count,
   input  logic signed [ole_pkg::VALUE_W-1:0]  rsp_first_value,
   input  logic signed [ole_pkg::VALUE_W-1:0]  rsp_last_value,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  checked,
   output int                                  full_seen,
   output int                                  empty_seen
);
   import ole_pkg::*;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] removed_value;
      logic [COUNT_W-1:0]        entry_count;
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] back_value;
   } list_result_type;

   // shadow copy of the list, front at index 0
   logic signed [VALUE_W-1:0] entries [CAPACITY];
   int                        fill = 0;
   list_result_type           expected_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      full_seen  = 0;
      empty_seen = 0;
   end

   task automatic apply_request(input logic [ACTION_W-1:0] act,
                                input logic signed [VALUE_W-1:0] val);
      list_result_type res;
      int              pos;
      res = '{ST_DONE, '0, '0, '0, '0};
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT: begin
            if (fill >= CAPACITY) begin
               res.status = ST_FULL;
               full_seen++;
            end else begin
               pos = 0;
               if (act == ACT_PUSH_BACK) begin
                  pos = fill;
               end else if (act == ACT_INSERT) begin
                  // ties go in front of equal entries
                  while (pos < fill && entries[pos] < val) pos++;
               end
               for (int i = fill; i > pos; i--) entries[i] = entries[i-1];
               entries[pos] = val;
               fill++;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (fill == 0) begin
               res.status = ST_EMPTY;
               empty_seen++;
            end else if (act == ACT_POP_FRONT) begin
               res.removed_value = entries[0];
               for (int i = 0; i < fill - 1; i++) entries[i] = entries[i+1];
               fill--;
            end else begin
               fill--;
               res.removed_value = entries[fill];
            end
         end
         default: ;  // unused codes leave the list alone
      endcase
      res.entry_count = fill[COUNT_W-1:0];
      if (fill > 0) begin
         res.front_value = entries[0];
         res.back_value  = entries[fill-1];
      end
      expected_q.push_back(res);
   endtask

   task automatic check_response();
      list_result_type want;
      if (expected_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: response with no request outstanding", $realtime);
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.status !== rsp_status || want.removed_value !== rsp_removed_value ||
          want.entry_count !== rsp_entry_count || want.front_value !== rsp_first_value ||
          want.back_value !== rsp_last_value) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: mismatch, expected status=%0d removed=%0d count=%0d front=%0d back=%0d",
                     $realtime, want.status, want.removed_value, want.entry_count,
                     want.front_value, want.back_value);
            $display("          got      status=%0d removed=%0d count=%0d front=%0d back=%0d",
                     rsp_status, rsp_removed_value, rsp_entry_count, rsp_first_value,
                     rsp_last_value);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         expected_q.delete();
      end else begin
         // a response always belongs to an earlier request, so check it first
         if (rsp_valid && !rsp_stall) check_response();
         if (req_valid && !req_stall) apply_request(req_action, req_value);
      end
      pending = expected_q.size();
   end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the ordered list engine: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import ole_pkg::*;

   localparam int unsigned CAPACITY       = 16;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          PHASES         = 12;
   localparam int          PHASE_ITEMS    = 136;
   localparam int          IDLE_PERCENT   = 12;
   // Codes past the last defined action; the block must ignore them.
   localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;
   localparam logic signed [VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MOST_POS = 32'sh7fff_ffff;

   typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [ACTION_W-1:0]       req_action = ACT_PUSH_BACK;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [VALUE_W-1:0] rsp_removed_value;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic signed [VALUE_W-1:0] rsp_first_value;
   logic signed [VALUE_W-1:0] rsp_last_value;

   int fail_count, pending, checked, full_seen, empty_seen;
   int sent = 0;
   int quiet_cycles = 0;
   bit calm = 1'b0;   // suppresses idling on both sides

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ordered_list_engine_core #(.CAPACITY(CAPACITY)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_first_value   (rsp_first_value),
      .rsp_last_value    (rsp_last_value)
   );

   ordered_list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_first_value   (rsp_first_value),
      .rsp_last_value    (rsp_last_value),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked           (checked),
      .full_seen         (full_seen),
      .empty_seen        (empty_seen)
   );

   // Response side: random stall, independent of rsp_valid, off during calm stretches.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Watchdog: too long without any transaction on either channel means a hang.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request and hold it until the block takes it. A random gap may come
   // first, during which valid is low. Otherwise valid stays high and only the
   // payload changes, so valid gets a single assignment per step.
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic signed [VALUE_W-1:0] val);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2, 8)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= val;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Values lean toward extremes and a small band around zero, so ties and
   // order-sensitive inserts are frequent; the rest is full-width random.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (r == 0) return MOST_NEG;
      if (r == 1) return MOST_POS;
      if (r <= 4) return $signed($urandom_range(8)) - 4;
      return $urandom;
   endfunction

   // Grow phases mostly push (to hit the full list), shrink phases mostly pop (to
   // drain through the last entry and into empty pops), mixed sits in between.
   function automatic logic [ACTION_W-1:0] pick_action(input phase_kind_type kind);
      int push_share;
      int r;
      push_share = (kind == PH_GROW) ? 72 : (kind == PH_SHRINK) ? 25 : 50;
      if ($urandom_range(99) < 3)
         return ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
      if ($urandom_range(99) < push_share) begin
         r = $urandom_range(3);
         if (r == 0) return ACT_PUSH_FRONT;
         if (r == 1) return ACT_PUSH_BACK;
         return ACT_INSERT;
      end
      return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
   endfunction

   initial begin
      phase_kind_type kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // empty list: both pops refused, unused code ignored
      send_request(ACT_POP_FRONT, 32'sd9);
      send_request(ACT_POP_BACK, -32'sd9);
      send_request(ACT_LAST_UNUSED, MOST_POS);
      // single entry removed from either end leaves a clean empty list
      send_request(ACT_PUSH_BACK, 32'sd5);
      send_request(ACT_POP_FRONT, '0);
      send_request(ACT_PUSH_FRONT, -32'sd6);
      send_request(ACT_POP_BACK, '0);
      // fill to capacity: extremes, ties on insert, then random content
      send_request(ACT_PUSH_FRONT, MOST_NEG);
      send_request(ACT_PUSH_BACK, MOST_POS);
      send_request(ACT_INSERT, 32'sd0);
      send_request(ACT_INSERT, 32'sd0);
      send_request(ACT_INSERT, -32'sd1);
      send_request(ACT_INSERT, 32'sd1);
      send_request(ACT_INSERT, MOST_NEG);
      send_request(ACT_INSERT, MOST_POS);
      for (int i = 0; i < CAPACITY - 8; i++)
         send_request((i % 3 == 0) ? ACT_PUSH_FRONT : ACT_INSERT, $urandom);
      // full list: every push kind refused
      send_request(ACT_PUSH_FRONT, 32'sd3);
      send_request(ACT_PUSH_BACK, 32'sd3);
      send_request(ACT_INSERT, 32'sd3);
      drain();

      // --- random part ---
      // phases cycle grow / shrink / mixed; two of them run with no idling at all
      for (int p = 0; p < PHASES; p++) begin
         kind = phase_kind_type'(p % 3);
         calm = (p == 4 || p == 5);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_request(pick_action(kind), pick_value());
         drain();
      end
      calm = 1'b0;

      // all requests in; let any stray response show up before the verdict
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);

      $display("run: %0d requests sent, %0d responses checked", sent, checked);
      $display("run: %0d pushes refused on a full list, %0d pops on an empty list",
               full_seen, empty_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/ole_pkg.sv
rtl/core/ole_ctrl.sv
rtl/core/ole_dpath.sv
rtl/core/ordered_list_engine_core.sv
tb/sv/ordered_list_checker.sv
tb/sv/tb.sv
